// ----- rtl/core/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Types, codes and helpers shared by the linear probing hash table modules.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int SZW         = 11;
   localparam int LIMW        = 8;
   localparam int CMDW        = 2;
   localparam int HASHW       = 32;
   localparam int KEYW        = 64;
   localparam int VALW        = 64;
   localparam int LENW        = 4;
   localparam int STW         = 2;
   localparam int KEY_BYTES   = 8;
   localparam int VALUE_BYTES = 8;

   localparam int MOD_BITS_PER_CYCLE = 4;
   localparam int MOD_CYCLES         = HASHW / MOD_BITS_PER_CYCLE;
   localparam int MOD_CNTW           = $clog2(MOD_CYCLES);

   localparam logic [CMDW-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMDW-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMDW-1:0] CMD_DELETE = 2'd2;

   localparam logic [STW-1:0] ST_OK      = 2'd0;
   localparam logic [STW-1:0] ST_MISS    = 2'd1;
   localparam logic [STW-1:0] ST_REFUSED = 2'd2;

   localparam logic REG_TABLE_SIZE = 1'b0;
   localparam logic REG_LOAD_LIMIT = 1'b1;

   localparam logic [SZW-1:0]  TABLE_SIZE_RESET = 11'd1024;
   localparam logic [LIMW-1:0] LOAD_LIMIT_RESET = 8'd192;

   typedef struct packed {
      logic            valid;
      logic [LENW-1:0] key_len;
      logic [KEYW-1:0] key;
      logic [LENW-1:0] value_len;
      logic [VALW-1:0] value;
   } slot_type;

   typedef struct packed {
      logic           busy;
      logic [SZW-1:0] rem;
   } mod_status_type;

   // keeps the low min(len, nbytes, 8) bytes
   function automatic logic [63:0] byte_mask(input logic [LENW-1:0] len, input int nbytes);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if ((i < int'(len)) && (i < nbytes)) begin
            m[8*i +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

// ----- rtl/core/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lpht_mod.sv -----
// ----------------------------------------------------------------------------
// lpht_mod
// Iterative hash modulo table size, four remainder steps per cycle.
// ----------------------------------------------------------------------------
module lpht_mod
   import lpht_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [HASHW-1:0] hash,
   input  logic [SZW-1:0]   size,
   output mod_status_type   status
);

   logic [HASHW-1:0]    div_ff, div_in;
   logic [SZW-1:0]      rem_ff, rem_in;
   logic [SZW-1:0]      size_ff;
   logic [MOD_CNTW-1:0] cnt_ff;
   logic                busy_ff;

   always_comb begin
      logic [SZW:0] r2;
      div_in = div_ff;
      rem_in = rem_ff;
      for (int i = 0; i < MOD_BITS_PER_CYCLE; i++) begin
         r2     = {rem_in, div_in[HASHW-1]};
         div_in = {div_in[HASHW-2:0], 1'b0};
         if (r2 >= {1'b0, size_ff}) begin
            r2 = r2 - {1'b0, size_ff};
         end
         rem_in = r2[SZW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + MOD_CNTW'(1);
         if (cnt_ff == MOD_CNTW'(MOD_CYCLES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff  <= hash;
         rem_ff  <= '0;
         size_ff <= size;
      end else if (busy_ff) begin
         div_ff <= div_in;
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.rem  = rem_ff;

endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed hash table with linear probing over one slot memory.
// ----------------------------------------------------------------------------
// After reset the slot memory is swept clear before the first request is
// taken. A request then runs the hash modulo in the iterative remainder
// unit, a start state that begins the walk, and the walk itself, which
// examines the slots in turn, since the slot memory returns one entry per
// cycle. Refused inserts and the unused command skip the modulo and the
// walk. A new request is taken while the previous result waits, but its
// walk starts only once that result has gone.
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CMDW-1:0]  req_command,
   input  logic [HASHW-1:0] req_hash_value,
   input  logic [KEYW-1:0]  req_key,
   input  logic [LENW-1:0]  req_key_len,
   input  logic [VALW-1:0]  req_value,
   input  logic [LENW-1:0]  req_value_len,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [STW-1:0]   rsp_status,
   output logic [VALW-1:0]  rsp_found_value,
   output logic [LENW-1:0]  rsp_found_value_len,
   output logic [SZW-1:0]   rsp_probes,
   output logic [SZW-1:0]   rsp_entry_total,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = $clog2(SLOTS);
   localparam int PW = ((AW > SZW) ? AW : SZW) + 1;
   localparam int SW = $bits(slot_type);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_START = 3'd3;
   localparam logic [2:0] S_PROBE = 3'd4;
   localparam logic [2:0] S_QUICK = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [SZW-1:0]  size_ff;
   logic [LIMW-1:0] limit_ff;
   logic [SZW-1:0]  count_ff, count_in;

   logic [CMDW-1:0] cmd_ff;
   logic [KEYW-1:0] key_ff;
   logic [LENW-1:0] klen_ff;
   logic [VALW-1:0] val_ff;
   logic [LENW-1:0] vlen_ff;
   logic            refuse_ff, refuse_in;

   logic [AW-1:0]   pos_ff, pos_in;
   logic [AW-1:0]   eval_ff, eval_in;
   logic [SZW-1:0]  probes_ff, probes_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_load;
   logic [STW-1:0]  rsp_status_ff, rsp_status_in;
   logic [VALW-1:0] rsp_value_ff, rsp_value_in;
   logic [LENW-1:0] rsp_vlen_ff, rsp_vlen_in;
   logic [SZW-1:0]  rsp_probes_ff, rsp_probes_in;

   logic [SZW-1:0]  eff_size;
   logic [PW-1:0]   pos_plus;
   logic [AW-1:0]   pos_next;
   logic            accept;
   logic            out_free;
   logic            cfg_write;
   logic [19:0]     need;
   logic [19:0]     allow;

   logic            mem_wr_en;
   logic [AW-1:0]   mem_wr_addr;
   slot_type        mem_wr_data;
   logic [SW-1:0]   mem_rd_data;
   slot_type        rd_slot;
   logic            mod_start;
   mod_status_type  mod_st;

   // configuration
   assign cfg_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= TABLE_SIZE_RESET;
         limit_ff <= LOAD_LIMIT_RESET;
      end else if (cfg_write) begin
         unique case (paddr[2])
            REG_TABLE_SIZE: size_ff  <= pwdata[SZW-1:0];
            REG_LOAD_LIMIT: limit_ff <= pwdata[LIMW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TABLE_SIZE: prdata = {{(32-SZW){1'b0}}, size_ff};
         REG_LOAD_LIMIT: prdata = {{(32-LIMW){1'b0}}, limit_ff};
         default:        prdata = '0;
      endcase
   end

   // size clamp and wrap
   always_comb begin
      if (size_ff == '0) begin
         eff_size = SZW'(1);
      end else if (32'(size_ff) > 32'(SLOTS)) begin
         eff_size = SZW'(SLOTS);
      end else begin
         eff_size = size_ff;
      end
   end

   assign pos_plus = PW'(pos_ff) + PW'(1);
   assign pos_next = (pos_plus == PW'(eff_size)) ? '0 : AW'(pos_plus);

   assign need  = {(SZW+1)'(count_ff) + (SZW+1)'(1), 8'd0};
   assign allow = 20'(limit_ff) * 20'(eff_size);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mod_start = accept;
   assign rd_slot   = slot_type'(mem_rd_data);

   lpht_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .hash   (req_hash_value),
      .size   (eff_size),
      .status (mod_st)
   );

   lpht_ram #(
      .WIDTH (SW),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (pos_ff),
      .rd_data (mem_rd_data)
   );

   // control
   always_comb begin
      logic [KEYW-1:0] kmask;
      logic            hit;
      logic            stop;
      logic [SZW-1:0]  pnext;
      kmask = byte_mask(klen_ff, KEY_BYTES);
      hit   = rd_slot.valid && (rd_slot.key_len == klen_ff) &&
              ((rd_slot.key & kmask) == key_ff);
      pnext = probes_ff + SZW'(1);
      stop  = !rd_slot.valid || hit || (pnext == eff_size);

      state_in      = state_ff;
      clr_in        = clr_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      eval_in       = eval_ff;
      probes_in     = probes_ff;
      refuse_in     = refuse_ff;
      rsp_load      = 1'b0;
      rsp_status_in = ST_MISS;
      rsp_value_in  = '0;
      rsp_vlen_in   = '0;
      rsp_probes_in = '0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = eval_ff;
      mem_wr_data   = rd_slot;

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               refuse_in = (req_command == CMD_INSERT) && (need > allow);
               if ((req_command == CMD_INSERT && need > allow) ||
                   (req_command != CMD_INSERT && req_command != CMD_LOOKUP &&
                    req_command != CMD_DELETE)) begin
                  state_in = S_QUICK;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_QUICK: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = refuse_ff ? ST_REFUSED : ST_MISS;
               state_in      = S_IDLE;
            end
         end
         S_MOD: begin
            if (!mod_st.busy && out_free) begin
               pos_in   = AW'(mod_st.rem);
               state_in = S_START;
            end
         end
         S_START: begin
            eval_in   = pos_ff;
            pos_in    = pos_next;
            probes_in = '0;
            state_in  = S_PROBE;
         end
         S_PROBE: begin
            if (!stop) begin
               eval_in   = pos_ff;
               pos_in    = pos_next;
               probes_in = pnext;
            end else begin
               rsp_load      = 1'b1;
               rsp_probes_in = pnext;
               state_in      = S_IDLE;
               priority case (1'b1)
                  (cmd_ff == CMD_INSERT && hit): begin
                     mem_wr_en             = 1'b1;
                     mem_wr_data.value     = val_ff;
                     mem_wr_data.value_len = vlen_ff;
                     rsp_status_in         = ST_OK;
                  end
                  (cmd_ff == CMD_INSERT && !rd_slot.valid): begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = '{valid: 1'b1, key_len: klen_ff, key: key_ff,
                                     value_len: vlen_ff, value: val_ff};
                     count_in      = count_ff + SZW'(1);
                     rsp_status_in = ST_OK;
                  end
                  (cmd_ff == CMD_INSERT): begin
                     rsp_status_in = ST_REFUSED;
                  end
                  (cmd_ff == CMD_LOOKUP && hit): begin
                     rsp_status_in = ST_OK;
                     rsp_value_in  = rd_slot.value;
                     rsp_vlen_in   = rd_slot.value_len;
                  end
                  (cmd_ff == CMD_DELETE && hit): begin
                     mem_wr_en         = 1'b1;
                     mem_wr_data.valid = 1'b0;
                     if (count_ff != '0) begin
                        count_in = count_ff - SZW'(1);
                     end
                     rsp_status_in = ST_OK;
                  end
                  default: ;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         key_ff  <= req_key & byte_mask(req_key_len, KEY_BYTES);
         klen_ff <= req_key_len;
         val_ff  <= req_value & byte_mask(req_value_len, VALUE_BYTES);
         vlen_ff <= req_value_len;
      end
      refuse_ff <= refuse_in;
      pos_ff    <= pos_in;
      eval_ff   <= eval_in;
      probes_ff <= probes_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_vlen_ff   <= rsp_vlen_in;
         rsp_probes_ff <= rsp_probes_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found_value     = rsp_value_ff;
   assign rsp_found_value_len = rsp_vlen_ff;
   assign rsp_probes          = rsp_probes_ff;
   assign rsp_entry_total     = count_ff;

`ifndef ASSERT_OFF
   a_no_transfer_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing sweep");

   a_write_only_when_walking: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_CLEAR || state_ff == S_PROBE))
      else $error("slot write outside sweep or probe walk");

   a_probes_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (probes_ff < eff_size))
      else $error("probe walk ran past table size");

   a_no_overwrite_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");
`endif

endmodule

// ----- tb/tb_linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Drives insert, lookup and delete requests through the hash table under a
// series of table sizes and load limits, with random stalls on both sides.
// A scoreboard keeps its own copy of the slots and checks every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_linear_probe_hash_table
   import lpht_pkg::*;
();

   localparam int                SLOT_COUNT = 1024;
   localparam logic [CMDW-1:0]   CMD_UNUSED = 2'd3;

   typedef struct {
      logic [STW-1:0]  status;
      logic [VALW-1:0] found_value;
      logic [LENW-1:0] found_value_len;
      logic [SZW-1:0]  probes;
      logic [SZW-1:0]  entry_total;
   } answer_type;

   class table_scoreboard;
      bit              valid_q[SLOT_COUNT];
      bit [KEYW-1:0]   key_q[SLOT_COUNT];
      bit [LENW-1:0]   klen_q[SLOT_COUNT];
      bit [VALW-1:0]   val_q[SLOT_COUNT];
      bit [LENW-1:0]   vlen_q[SLOT_COUNT];
      int unsigned     count;
      bit [SZW-1:0]    size_reg;
      bit [LIMW-1:0]   limit_reg;
      answer_type      pending[$];
      int              mismatches;
      int              checked;

      function new();
         count     = 0;
         size_reg  = TABLE_SIZE_RESET;
         limit_reg = LOAD_LIMIT_RESET;
      endfunction

      function bit [63:0] keep_bytes(bit [LENW-1:0] len);
         bit [63:0] m;
         m = '0;
         for (int i = 0; i < 8; i++) begin
            if (i < int'(len)) m[8*i +: 8] = 8'hFF;
         end
         return m;
      endfunction

      function void note_request(bit [CMDW-1:0] cmd, bit [HASHW-1:0] h,
                                 bit [KEYW-1:0] k, bit [LENW-1:0] kl,
                                 bit [VALW-1:0] v, bit [LENW-1:0] vl);
         answer_type  a;
         int unsigned size;
         int unsigned pos;
         int unsigned n;
         bit          hit;
         bit          empty;
         bit [63:0]   km;
         bit [63:0]   key;
         bit [63:0]   val;
         km    = keep_bytes(kl);
         key   = k & km;
         val   = v & keep_bytes(vl);
         size  = (size_reg < 1) ? 1 : ((size_reg > SLOT_COUNT) ? SLOT_COUNT : size_reg);
         pos   = h % size;
         n     = 0;
         hit   = 0;
         empty = 0;
         a.status = ST_MISS;
         a.found_value = '0;
         a.found_value_len = '0;
         if (cmd == CMD_UNUSED) begin
            a.status = ST_MISS;
         end else if (cmd == CMD_INSERT &&
                      longint'(count + 1) * 256 > longint'(limit_reg) * size) begin
            a.status = ST_REFUSED;
         end else begin
            while (n < size) begin
               n++;
               if (!valid_q[pos]) begin
                  empty = 1;
                  break;
               end
               if (klen_q[pos] == kl && (key_q[pos] & km) == key) begin
                  hit = 1;
                  break;
               end
               pos = (pos + 1) % size;
            end
            if (cmd == CMD_INSERT) begin
               if (hit) begin
                  val_q[pos] = val;
                  vlen_q[pos] = vl;
                  a.status = ST_OK;
               end else if (empty) begin
                  valid_q[pos] = 1;
                  key_q[pos] = key;
                  klen_q[pos] = kl;
                  val_q[pos] = val;
                  vlen_q[pos] = vl;
                  count++;
                  a.status = ST_OK;
               end else begin
                  a.status = ST_REFUSED;
               end
            end else if (cmd == CMD_LOOKUP) begin
               if (hit) begin
                  a.found_value = val_q[pos];
                  a.found_value_len = vlen_q[pos];
                  a.status = ST_OK;
               end
            end else if (hit) begin
               valid_q[pos] = 0;
               if (count > 0) count--;
               a.status = ST_OK;
            end
         end
         a.probes = n[SZW-1:0];
         a.entry_total = count[SZW-1:0];
         pending.push_back(a);
      endfunction

      function void check_response(answer_type got);
         answer_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with no request outstanding");
            return;
         end
         want = pending.pop_front();
         if (got.status != want.status || got.found_value != want.found_value ||
             got.found_value_len != want.found_value_len || got.probes != want.probes ||
             got.entry_total != want.entry_total) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d: want st=%0d val=%h len=%0d pr=%0d tot=%0d",
                        checked, want.status, want.found_value, want.found_value_len,
                        want.probes, want.entry_total);
               $display("   got st=%0d val=%h len=%0d pr=%0d tot=%0d",
                        got.status, got.found_value, got.found_value_len,
                        got.probes, got.entry_total);
            end
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   logic [CMDW-1:0]  req_command = '0;
   logic [HASHW-1:0] req_hash_value = '0;
   logic [KEYW-1:0]  req_key = '0;
   logic [LENW-1:0]  req_key_len = '0;
   logic [VALW-1:0]  req_value = '0;
   logic [LENW-1:0]  req_value_len = '0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   logic [STW-1:0]   rsp_status;
   logic [VALW-1:0]  rsp_found_value;
   logic [LENW-1:0]  rsp_found_value_len;
   logic [SZW-1:0]   rsp_probes;
   logic [SZW-1:0]   rsp_entry_total;
   logic             psel = 0;
   logic             penable = 0;
   logic             pwrite = 0;
   logic [2:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   table_scoreboard  sb = new();
   bit               idle_on = 1;
   int               stall_left = 0;
   int               requests = 0;
   bit [KEYW-1:0]    pool_key[40];
   bit [LENW-1:0]    pool_len[40];
   bit [HASHW-1:0]   pool_hash[40];

   linear_probe_hash_table i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      answer_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status = rsp_status;
         got.found_value = rsp_found_value;
         got.found_value_len = rsp_found_value_len;
         got.probes = rsp_probes;
         got.entry_total = rsp_entry_total;
         sb.check_response(got);
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   task automatic write_reg(input logic index, input logic [31:0] data);
      @(posedge clock);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      if (index == REG_TABLE_SIZE) sb.size_reg = data[SZW-1:0];
      else sb.limit_reg = data[LIMW-1:0];
   endtask

   task automatic send(input logic [CMDW-1:0] cmd, input logic [HASHW-1:0] h,
                       input logic [KEYW-1:0] k, input logic [LENW-1:0] kl,
                       input logic [VALW-1:0] v, input logic [LENW-1:0] vl);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_hash_value <= h;
      req_key <= k;
      req_key_len <= kl;
      req_value <= v;
      req_value_len <= vl;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, h, k, kl, v, vl);
      requests++;
   endtask

   task automatic drain();
      @(posedge clock);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic refill_pool();
      for (int i = 0; i < 40; i++) begin
         pool_key[i] = {$urandom, $urandom};
         pool_len[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(1, 8);
         pool_hash[i] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom;
      end
   endtask

   task automatic random_requests(input int n);
      int               i;
      int               w;
      logic [CMDW-1:0]  cmd;
      logic [KEYW-1:0]  m;
      logic [KEYW-1:0]  k;
      logic [HASHW-1:0] h;
      for (int j = 0; j < n; j++) begin
         i = $urandom_range(0, 39);
         w = $urandom_range(0, 99);
         cmd = (w < 45) ? CMD_INSERT : (w < 75) ? CMD_LOOKUP :
               (w < 95) ? CMD_DELETE : CMD_UNUSED;
         m = sb.keep_bytes(pool_len[i]);
         k = (pool_key[i] & m) | ({$urandom, $urandom} & ~m);
         h = ($urandom_range(0, 9) == 0) ? $urandom : pool_hash[i];
         send(cmd, h, k, pool_len[i], {$urandom, $urandom}, $urandom_range(0, 15));
      end
   endtask

   initial begin
      int sizes[8];
      int limits[8];
      sizes  = '{32, 4, 1, 0, 2047, 16, 7, 1024};
      limits = '{255, 255, 255, 128, 255, 0, 1, 192};
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed part at reset settings
      send(CMD_INSERT, 32'h0, 64'h0, 4'd1, 64'h0, 4'd1);
      send(CMD_INSERT, 32'hFFFF_FFFF, '1, 4'd8, '1, 4'd8);
      send(CMD_LOOKUP, 32'hFFFF_FFFF, '1, 4'd8, '0, 4'd0);
      send(CMD_LOOKUP, 32'h0, 64'hFFFF_FFFF_FFFF_FF00, 4'd1, '0, 4'd0);
      send(CMD_INSERT, 32'h0, 64'h0, 4'd1, 64'h1234_5678_9ABC_DEF0, 4'd15);
      send(CMD_LOOKUP, 32'h0, 64'h0, 4'd1, '0, 4'd0);
      send(CMD_LOOKUP, 32'h0, 64'h0, 4'd2, '0, 4'd0);
      send(CMD_INSERT, 32'd1024, 64'hAA, 4'd0, '1, 4'd0);
      send(CMD_INSERT, 32'd1024, 64'hBB, 4'd15, '1, 4'd9);
      send(CMD_LOOKUP, 32'd1024, 64'hBB, 4'd15, '0, 4'd0);
      send(CMD_LOOKUP, 32'd1024, 64'h55, 4'd0, '0, 4'd0);
      send(CMD_DELETE, 32'h0, 64'h0, 4'd1, '0, 4'd0);
      send(CMD_DELETE, 32'h0, 64'h0, 4'd1, '0, 4'd0);
      send(CMD_LOOKUP, 32'd1024, 64'hBB, 4'd15, '0, 4'd0);
      send(CMD_UNUSED, 32'h5555_AAAA, '1, 4'd8, '1, 4'd8);
      send(CMD_DELETE, 32'hFFFF_FFFF, '1, 4'd8, '0, 4'd0);
      send(CMD_LOOKUP, 32'hFFFF_FFFF, '1, 4'd8, '0, 4'd0);
      send(CMD_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0000, 4'd8,
           64'h8000_0000_0000_0001, 4'd8);
      send(CMD_LOOKUP, 32'h8000_0000, 64'h8000_0000_0000_0000, 4'd8, '0, 4'd0);
      drain();

      // sweep through sizes and limits; the last setting runs without stalls
      for (int p = 0; p < 8; p++) begin
         write_reg(REG_TABLE_SIZE, sizes[p]);
         write_reg(REG_LOAD_LIMIT, limits[p]);
         if (p != 1) refill_pool();
         if (p == 7) idle_on = 0;
         random_requests(92);
         drain();
      end

      repeat (20) @(posedge clock);
      $display("%0d requests over 9 table settings, %0d responses checked",
               requests, sb.checked);
      $display("sizes 0 to 2047 written, load limits 0 to 255, full walks after shrinking");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
